FILE: rtl/core/olh_pkg.sv
package olh_pkg;

   // request and response field types
   typedef logic [2:0]  cmd_type;
   typedef logic [5:0]  position_type;
   typedef logic [31:0] handle_type;
   typedef logic [1:0]  status_type;
   typedef logic [6:0]  entry_count_type;

   // command codes
   localparam cmd_type CMD_APPEND    = 3'd0;
   localparam cmd_type CMD_CLEAR     = 3'd1;
   localparam cmd_type CMD_READ      = 3'd2;
   localparam cmd_type CMD_SWAP_NEXT = 3'd3;
   localparam cmd_type CMD_SWAP_PREV = 3'd4;
   localparam cmd_type CMD_REMOVE    = 3'd5;
   localparam cmd_type CMD_REPLACE   = 3'd6;

   // status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_NULL  = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

   // store read address select
   typedef logic [1:0] rd_sel_type;
   localparam rd_sel_type RD_POS  = 2'd0;
   localparam rd_sel_type RD_NBR  = 2'd1;
   localparam rd_sel_type RD_IDX1 = 2'd2;
   localparam rd_sel_type RD_IDX2 = 2'd3;

   // store write address and data select
   typedef logic [2:0] wr_sel_type;
   localparam wr_sel_type WR_APPEND  = 3'd0;
   localparam wr_sel_type WR_REPLACE = 3'd1;
   localparam wr_sel_type WR_SWAP_A  = 3'd2;
   localparam wr_sel_type WR_SWAP_B  = 3'd3;
   localparam wr_sel_type WR_SHIFT   = 3'd4;
   localparam wr_sel_type WR_ZERO    = 3'd5;

   // controller to datapath commands
   typedef struct packed {
      logic       latch_req;
      logic       check;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       cap_tmp;
      logic       cap_hout;
      logic       idx_inc;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       load_rsp;
   } olh_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      cmd_type cmd;
      logic    is_null;
      logic    is_full;
      logic    in_range;
      logic    has_nbr;
      logic    has_next;
      logic    shift_more;
   } olh_stat_type;

endpackage

FILE: rtl/core/olh_req_if.sv
interface olh_req_if import olh_pkg::*;;
   logic         valid;
   logic         ready;
   cmd_type      cmd;
   position_type position;
   handle_type   handle_in;

   modport source (output valid, output cmd, output position, output handle_in, input ready);
   modport sink (input valid, input cmd, input position, input handle_in, output ready);
endinterface

FILE: rtl/core/olh_rsp_if.sv
interface olh_rsp_if import olh_pkg::*;;
   logic            valid;
   logic            ready;
   status_type      status;
   handle_type      handle_out;
   entry_count_type entry_count;

   modport source (output valid, output status, output handle_out, output entry_count,
                   input ready);
   modport sink (input valid, input status, input handle_out, input entry_count,
                 output ready);
endinterface

FILE: rtl/core/olh_ram.sv
module olh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/olh_ctrl.sv
module olh_ctrl import olh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  olh_stat_type stat,
   output olh_ctrl_type ctrl
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_RD_B   = 4'd2;
   localparam logic [3:0] S_SWAP_A = 4'd3;
   localparam logic [3:0] S_SWAP_B = 4'd4;
   localparam logic [3:0] S_SHIFT  = 4'd5;
   localparam logic [3:0] S_ZERO   = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl         = '0;
      ctrl.rd_sel  = RD_POS;
      ctrl.wr_sel  = WR_APPEND;
      req_ready    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.latch_req = 1'b1;
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            ctrl.check = 1'b1;
            state_in   = S_DONE;
            case (stat.cmd)
               CMD_APPEND: begin
                  if (!stat.is_null && !stat.is_full) begin
                     ctrl.wr_en   = 1'b1;
                     ctrl.wr_sel  = WR_APPEND;
                     ctrl.cnt_inc = 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  ctrl.cnt_clr = 1'b1;
               end
               CMD_READ, CMD_REMOVE: begin
                  if (stat.in_range) begin
                     ctrl.rd_en = 1'b1;
                     state_in   = S_RD_B;
                  end
               end
               CMD_SWAP_NEXT, CMD_SWAP_PREV: begin
                  if (stat.in_range && stat.has_nbr) begin
                     ctrl.rd_en = 1'b1;
                     state_in   = S_RD_B;
                  end
               end
               CMD_REPLACE: begin
                  if (!stat.is_null && stat.in_range) begin
                     ctrl.rd_en = 1'b1;
                     state_in   = S_RD_B;
                  end
               end
               default: begin
               end
            endcase
         end
         S_RD_B: begin
            ctrl.cap_tmp = 1'b1;
            state_in     = S_DONE;
            case (stat.cmd)
               CMD_READ: begin
                  ctrl.cap_hout = 1'b1;
               end
               CMD_REPLACE: begin
                  ctrl.cap_hout = 1'b1;
                  ctrl.wr_en    = 1'b1;
                  ctrl.wr_sel   = WR_REPLACE;
               end
               CMD_SWAP_NEXT, CMD_SWAP_PREV: begin
                  ctrl.rd_en  = 1'b1;
                  ctrl.rd_sel = RD_NBR;
                  state_in    = S_SWAP_A;
               end
               CMD_REMOVE: begin
                  ctrl.cap_hout = 1'b1;
                  if (stat.has_next) begin
                     ctrl.rd_en  = 1'b1;
                     ctrl.rd_sel = RD_IDX1;
                     state_in    = S_SHIFT;
                  end else begin
                     state_in = S_ZERO;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SWAP_A: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_sel = WR_SWAP_A;
            state_in    = S_SWAP_B;
         end
         S_SWAP_B: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_sel = WR_SWAP_B;
            state_in    = S_DONE;
         end
         S_SHIFT: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_sel  = WR_SHIFT;
            ctrl.idx_inc = 1'b1;
            if (stat.shift_more) begin
               ctrl.rd_en  = 1'b1;
               ctrl.rd_sel = RD_IDX2;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_sel  = WR_ZERO;
            ctrl.cnt_dec = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.load_rsp = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/olh_dp.sv
module olh_dp import olh_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  olh_ctrl_type    ctrl,
   output olh_stat_type    stat,
   input  cmd_type         req_cmd,
   input  position_type    req_position,
   input  handle_type      req_handle_in,
   output status_type      rsp_status,
   output handle_type      rsp_handle_out,
   output entry_count_type rsp_entry_count
);

   localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CountW = $clog2(MAX_ENTRIES + 1);
   localparam int CmpW   = ((CountW > 6) ? CountW : 6) + 1;

   cmd_type         cmd_ff, cmd_in;
   position_type    pos_ff, pos_in;
   handle_type      hin_ff, hin_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [CountW-1:0] count_ff, count_in;
   handle_type      tmp_ff, tmp_in;
   handle_type      hout_ff, hout_in;
   status_type      status_ff, status_in;
   status_type      rsp_status_ff, rsp_status_in;
   handle_type      rsp_hout_ff, rsp_hout_in;
   entry_count_type rsp_count_ff, rsp_count_in;

   logic [CmpW-1:0] pos_x, cnt_x, idx_x;
   logic [AW-1:0]   pos_addr, nbr_addr, rd_addr, wr_addr;
   handle_type      wr_data, rd_data;
   status_type      status_chk;

   assign pos_x    = CmpW'(pos_ff);
   assign cnt_x    = CmpW'(count_ff);
   assign idx_x    = CmpW'(idx_ff);
   assign pos_addr = AW'(pos_ff);
   assign nbr_addr = (cmd_ff == CMD_SWAP_NEXT) ? pos_addr + AW'(1) : pos_addr - AW'(1);

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.is_null    = (hin_ff == '0);
      stat.is_full    = (count_ff == CountW'(MAX_ENTRIES));
      stat.in_range   = (pos_x < cnt_x);
      stat.has_next   = ((pos_x + CmpW'(1)) < cnt_x);
      stat.has_nbr    = (cmd_ff == CMD_SWAP_NEXT) ? stat.has_next : (pos_x != '0);
      stat.shift_more = ((idx_x + CmpW'(2)) < cnt_x);
   end

   always_comb begin
      case (cmd_ff)
         CMD_APPEND: begin
            status_chk = stat.is_null ? ST_NULL : (stat.is_full ? ST_FULL : ST_OK);
         end
         CMD_READ, CMD_SWAP_NEXT, CMD_SWAP_PREV, CMD_REMOVE: begin
            status_chk = stat.in_range ? ST_OK : ST_RANGE;
         end
         CMD_REPLACE: begin
            status_chk = stat.is_null ? ST_NULL : (stat.in_range ? ST_OK : ST_RANGE);
         end
         default: begin
            status_chk = ST_OK;
         end
      endcase
   end

   // store address and data steering
   always_comb begin
      case (ctrl.rd_sel)
         RD_POS:  rd_addr = pos_addr;
         RD_NBR:  rd_addr = nbr_addr;
         RD_IDX1: rd_addr = idx_ff + AW'(1);
         RD_IDX2: rd_addr = idx_ff + AW'(2);
         default: rd_addr = pos_addr;
      endcase
      case (ctrl.wr_sel)
         WR_APPEND: begin
            wr_addr = AW'(count_ff);
            wr_data = hin_ff;
         end
         WR_REPLACE: begin
            wr_addr = pos_addr;
            wr_data = hin_ff;
         end
         WR_SWAP_A: begin
            wr_addr = pos_addr;
            wr_data = rd_data;
         end
         WR_SWAP_B: begin
            wr_addr = nbr_addr;
            wr_data = tmp_ff;
         end
         WR_SHIFT: begin
            wr_addr = idx_ff;
            wr_data = rd_data;
         end
         WR_ZERO: begin
            wr_addr = AW'(count_ff - CountW'(1));
            wr_data = '0;
         end
         default: begin
            wr_addr = pos_addr;
            wr_data = '0;
         end
      endcase
   end

   olh_ram #(
      .WIDTH ($bits(handle_type)),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      cmd_in        = ctrl.latch_req ? req_cmd : cmd_ff;
      pos_in        = ctrl.latch_req ? req_position : pos_ff;
      hin_in        = ctrl.latch_req ? req_handle_in : hin_ff;
      idx_in        = idx_ff;
      if (ctrl.latch_req) begin
         idx_in = AW'(req_position);
      end else if (ctrl.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end
      tmp_in        = ctrl.cap_tmp ? rd_data : tmp_ff;
      hout_in       = hout_ff;
      if (ctrl.check) begin
         hout_in = '0;
      end else if (ctrl.cap_hout) begin
         hout_in = rd_data;
      end
      status_in     = ctrl.check ? status_chk : status_ff;
      count_in      = count_ff;
      if (ctrl.cnt_clr) begin
         count_in = '0;
      end else if (ctrl.cnt_inc) begin
         count_in = count_ff + CountW'(1);
      end else if (ctrl.cnt_dec) begin
         count_in = count_ff - CountW'(1);
      end
      rsp_status_in = ctrl.load_rsp ? status_ff : rsp_status_ff;
      rsp_hout_in   = ctrl.load_rsp ? hout_ff : rsp_hout_ff;
      rsp_count_in  = ctrl.load_rsp ? entry_count_type'(count_ff) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      hin_ff        <= hin_in;
      idx_ff        <= idx_in;
      tmp_ff        <= tmp_in;
      hout_ff       <= hout_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hout_ff   <= rsp_hout_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_hout_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: rtl/core/ordered_handle_list_top.sv
// channel   dir   handshake      payload
// req_if    in    valid/ready    cmd, position, handle_in
// rsp_if    out   valid/ready    status, handle_out, entry_count
//
// states per request, from accept to response valid: append, clear, failed commands
//    and edge swaps pass CHECK and DONE; read and replace add RD_B; swaps add RD_B,
//    SWAP_A and SWAP_B; remove adds RD_B, a SHIFT per entry behind the position, and
//    ZERO, one entry moved per cycle through the single write port of the entry store
// one request is in work at a time; the next is taken while a response still waits,
//    at the earliest in the same cycle as the response goes valid
// reset clears the controller and the count only; slots at or above the count are
//    never read, so the entry store needs no clearing pass
// a stalled response holds in its output register and stalls only the next request
module ordered_handle_list_top import olh_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input logic       clock,
   input logic       reset,
   olh_req_if.sink   req_if,
   olh_rsp_if.source rsp_if
);

   olh_ctrl_type ctrl;
   olh_stat_type stat;

   // sequencer: request decode, store access order, response handshake
   olh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // datapath: request latch, count, entry store, response registers
   olh_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_cmd         (req_if.cmd),
      .req_position    (req_if.position),
      .req_handle_in   (req_if.handle_in),
      .rsp_status      (rsp_if.status),
      .rsp_handle_out  (rsp_if.handle_out),
      .rsp_entry_count (rsp_if.entry_count)
   );

`ifndef SYNTH
   // a request in work blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while busy");

   // failed commands never return a handle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_OK) |-> (rsp_if.handle_out == '0))
      else $error("handle returned on failure");

   // append never writes past a full list
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.wr_en && ctrl.wr_sel == WR_APPEND) |-> (!stat.is_full && ctrl.cnt_inc))
      else $error("append write on full list");
`endif

endmodule

FILE: dv/tb.sv
module tb;
   import olh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ENTRIES = 64;
   localparam int RANDOM_REQS = 1600;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 80;
   localparam int MAX_REPORTS = 10;
   // cmd code left unused by the block, should be a no-op
   localparam cmd_type CMD_UNUSED = 3'd7;

   // stimulus phases of the random part
   typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_kind_type;

   // one pending request, drain asks the sender to wait for all responses first
   typedef struct {
      cmd_type      cmd;
      position_type position;
      handle_type   handle;
      bit           drain;
   } list_req_type;

   typedef struct {
      status_type      status;
      handle_type      handle;
      entry_count_type entries;
   } list_rsp_type;

   logic clock;
   logic reset;

   olh_req_if req_ch ();
   olh_rsp_if rsp_ch ();

   ordered_handle_list_top #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // shadow copy of the list, updated on every accepted request
   handle_type list_slots [MAX_ENTRIES];
   int         list_len;

   list_req_type  pending_reqs [$];
   list_rsp_type  expected_rsps [$];
   list_req_type  next_req;

   int  gen_len;          // entry count as seen while generating requests
   int  reqs_total;
   int  reqs_accepted;
   int  error_count;
   int  cycle_count;
   bit  req_done;         // current request was taken at the last rising edge

   always #5 clock = ~clock;

   // compute the response of one command and update the shadow list
   function automatic list_rsp_type apply_list_command(cmd_type cmd, position_type pos,
                                                       handle_type hin);
      list_rsp_type r;
      handle_type   t;
      int           p;
      bit           in_range;
      p = int'(pos);
      in_range = (p < list_len);
      r.status = ST_OK;
      r.handle = '0;
      case (cmd)
         CMD_APPEND: begin
            // null check wins over the full check
            if (hin == '0) r.status = ST_NULL;
            else if (list_len >= MAX_ENTRIES) r.status = ST_FULL;
            else begin
               list_slots[list_len] = hin;
               list_len++;
            end
         end
         CMD_CLEAR: begin
            foreach (list_slots[i]) list_slots[i] = '0;
            list_len = 0;
         end
         CMD_READ: begin
            if (!in_range) r.status = ST_RANGE;
            else r.handle = list_slots[p];
         end
         CMD_SWAP_NEXT: begin
            // swap at the last entry is a successful no-op
            if (!in_range) r.status = ST_RANGE;
            else if (p + 1 < list_len) begin
               t = list_slots[p];
               list_slots[p] = list_slots[p + 1];
               list_slots[p + 1] = t;
            end
         end
         CMD_SWAP_PREV: begin
            // swap at entry zero is a successful no-op
            if (!in_range) r.status = ST_RANGE;
            else if (p > 0) begin
               t = list_slots[p];
               list_slots[p] = list_slots[p - 1];
               list_slots[p - 1] = t;
            end
         end
         CMD_REMOVE: begin
            if (!in_range) r.status = ST_RANGE;
            else begin
               r.handle = list_slots[p];
               for (int i = p; i + 1 < list_len; i++) list_slots[i] = list_slots[i + 1];
               // vacated last slot goes null
               list_slots[list_len - 1] = '0;
               list_len--;
            end
         end
         CMD_REPLACE: begin
            // null check comes before the index check
            if (hin == '0) r.status = ST_NULL;
            else if (!in_range) r.status = ST_RANGE;
            else begin
               r.handle = list_slots[p];
               if (r.handle != '0) list_slots[p] = hin;
            end
         end
         default: begin
         end
      endcase
      r.entries = entry_count_type'(list_len);
      return r;
   endfunction

   // queue a request and track the entry count it leaves behind
   task automatic queue_cmd(cmd_type cmd, position_type pos, handle_type hin, bit drain);
      list_req_type q;
      q.cmd = cmd;
      q.position = pos;
      q.handle = hin;
      q.drain = drain;
      pending_reqs.push_back(q);
      case (cmd)
         CMD_APPEND: if (hin != '0 && gen_len < MAX_ENTRIES) gen_len++;
         CMD_CLEAR:  gen_len = 0;
         CMD_REMOVE: if (int'(pos) < gen_len) gen_len--;
         default: begin
         end
      endcase
   endtask

   // command mix per phase: grow fills toward full, shrink drains, mix wanders
   function automatic cmd_type pick_cmd(phase_kind_type kind);
      int r;
      r = $urandom_range(99);
      case (kind)
         PH_GROW: begin
            if (r < 60) return CMD_APPEND;
            if (r < 70) return CMD_READ;
            if (r < 78) return CMD_SWAP_NEXT;
            if (r < 86) return CMD_SWAP_PREV;
            if (r < 93) return CMD_REPLACE;
            if (r < 98) return CMD_REMOVE;
            return CMD_UNUSED;
         end
         PH_SHRINK: begin
            if (r < 15) return CMD_APPEND;
            if (r < 60) return CMD_REMOVE;
            if (r < 72) return CMD_READ;
            if (r < 80) return CMD_SWAP_NEXT;
            if (r < 88) return CMD_SWAP_PREV;
            if (r < 98) return CMD_REPLACE;
            return CMD_UNUSED;
         end
         default: begin
            if (r < 30) return CMD_APPEND;
            if (r < 55) return CMD_REMOVE;
            if (r < 67) return CMD_READ;
            if (r < 77) return CMD_SWAP_NEXT;
            if (r < 87) return CMD_SWAP_PREV;
            if (r < 95) return CMD_REPLACE;
            if (r < 98) return CMD_CLEAR;
            return CMD_UNUSED;
         end
      endcase
   endfunction

   // mostly valid indexes, leaning on both ends, plus some out of range
   function automatic position_type pick_position();
      int r;
      r = $urandom_range(99);
      if (gen_len == 0 || r < 10) return position_type'($urandom_range(MAX_ENTRIES - 1));
      if (r < 18) return position_type'((gen_len < MAX_ENTRIES) ? gen_len : gen_len - 1);
      if (r < 33) return '0;
      if (r < 48) return position_type'(gen_len - 1);
      return position_type'($urandom_range(gen_len - 1));
   endfunction

   function automatic handle_type pick_handle();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 8) return '1;
      return handle_type'($urandom());
   endfunction

   // no idling on either side for a stretch in the middle of the run
   function automatic bit no_idle_stretch();
      return reqs_accepted >= 700 && reqs_accepted < 1000;
   endfunction

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   // driver and response ready, both change on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_ch.valid || req_done) begin
            req_done = 1'b0;
            // hold back a drain request until every response is in
            if (pending_reqs.size() != 0 &&
                !(pending_reqs[0].drain && expected_rsps.size() != 0) &&
                (no_idle_stretch() || $urandom_range(99) >= 35)) begin
               next_req = pending_reqs.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.cmd       <= next_req.cmd;
               req_ch.position  <= next_req.position;
               req_ch.handle_in <= next_req.handle;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= no_idle_stretch() || ($urandom_range(99) >= 35);
      end
   end

   // sample both handshakes on the rising edge
   always @(posedge clock) begin
      list_rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else if (!reset) begin
         // request taken: predict its response now
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(apply_list_command(req_ch.cmd, req_ch.position,
                                                       req_ch.handle_in));
            reqs_accepted++;
            req_done = 1'b1;
         end
         // response taken: compare against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               note_error($sformatf("unexpected response: status %0d handle %h count %0d",
                                    rsp_ch.status, rsp_ch.handle_out, rsp_ch.entry_count));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.handle_out !== want.handle ||
                   rsp_ch.entry_count !== want.entries) begin
                  note_error($sformatf(
                     "mismatch: status %0d/%0d handle %h/%h count %0d/%0d (exp/act)",
                     want.status, rsp_ch.status, want.handle, rsp_ch.handle_out,
                     want.entries, rsp_ch.entry_count));
               end
            end
         end
      end
   end

   initial begin
      phase_kind_type kind;
      int             phase_len;
      int             n;
      bit             drain;

      // every input known from time zero
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_APPEND;
      req_ch.position  = '0;
      req_ch.handle_in = '0;
      rsp_ch.ready     = 1'b0;
      foreach (list_slots[i]) list_slots[i] = '0;
      list_len = 0;
      gen_len = 0;
      reqs_accepted = 0;
      error_count = 0;
      cycle_count = 0;
      req_done = 1'b0;

      // directed: empty list, null checks, edge swaps, remove, unused cmd, clear
      queue_cmd(CMD_READ,      6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_SWAP_NEXT, 6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_SWAP_PREV, 6'd63, 32'h0000_0000, 1'b0);
      queue_cmd(CMD_REMOVE,    6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_REPLACE,   6'd0,  32'h0000_0005, 1'b0);
      queue_cmd(CMD_REPLACE,   6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_APPEND,    6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_APPEND,    6'd63, 32'hFFFF_FFFF, 1'b0);
      queue_cmd(CMD_APPEND,    6'd0,  32'h0000_0001, 1'b0);
      queue_cmd(CMD_APPEND,    6'd0,  32'hA5A5_A5A5, 1'b0);
      queue_cmd(CMD_READ,      6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_READ,      6'd2,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_READ,      6'd3,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_SWAP_NEXT, 6'd2,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_SWAP_PREV, 6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_SWAP_NEXT, 6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_SWAP_PREV, 6'd2,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_REPLACE,   6'd1,  32'h5A5A_5A5A, 1'b0);
      queue_cmd(CMD_REPLACE,   6'd1,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_REMOVE,    6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_READ,      6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_UNUSED,    6'd63, 32'hFFFF_FFFF, 1'b0);
      queue_cmd(CMD_REMOVE,    6'd1,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_CLEAR,     6'd0,  32'h0000_0000, 1'b0);
      queue_cmd(CMD_READ,      6'd0,  32'h0000_0000, 1'b0);

      // random phases; the first and some later ones start after a full drain
      n = 0;
      while (n < RANDOM_REQS) begin
         kind = phase_kind_type'($urandom_range(2));
         phase_len = $urandom_range(200, 30);
         drain = (n == 0) || ($urandom_range(3) == 0);
         for (int k = 0; k < phase_len && n < RANDOM_REQS; k++) begin
            queue_cmd(pick_cmd(kind), pick_position(), pick_handle(), drain && k == 0);
            n++;
         end
      end
      reqs_total = pending_reqs.size();

      // synchronous reset, released on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests taken and all responses back, then a quiet tail
      while (reqs_accepted < reqs_total || expected_rsps.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
